// ===== hw/rtl/hslp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hslp_pkg;

    localparam logic [1:0] MODE_ADD     = 2'd0;
    localparam logic [1:0] MODE_REMOVE  = 2'd1;
    localparam logic [1:0] MODE_FIND    = 2'd2;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_FILLED  = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hslp_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Reduce the hash modulo the active size, one quotient bit per cycle.
module hslp_mod #(
    parameter int HASH_BITS = 32,
    parameter int IDX_BITS  = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [HASH_BITS-1:0] dividend,
    input  wire logic [IDX_BITS:0]    divisor,
    output logic                      done,
    output logic [IDX_BITS-1:0]       remainder
);
    localparam int CNT_BITS = $clog2(HASH_BITS + 1);

    logic [IDX_BITS+1:0]  rem_reg, rem_next;
    logic [HASH_BITS-1:0] shf_reg, shf_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [IDX_BITS+1:0]  trial;

    // Shift in one dividend bit and subtract when it fits
    always_comb begin
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[IDX_BITS:0], shf_reg[HASH_BITS-1]};
        if (start) begin
            rem_next  = '0;
            shf_next  = dividend;
            cnt_next  = CNT_BITS'(HASH_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            shf_next = shf_reg << 1;
            if (trial >= {1'b0, divisor})
                rem_next = trial - {1'b0, divisor};
            else
                rem_next = trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        shf_reg <= shf_next;
    end

    assign done      = !busy_reg;
    assign remainder = rem_reg[IDX_BITS-1:0];
endmodule
`default_nettype wire

// ===== hw/rtl/hslp_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Slot memory: mark and key per slot, one write and one registered read.
module hslp_store #(
    parameter int IDX_BITS = 8,
    parameter int KEY_BITS = 32
) (
    input  wire logic                aclk,
    input  wire logic [IDX_BITS-1:0] rd_addr,
    output logic [1:0]               rd_mark,
    output logic [KEY_BITS-1:0]      rd_key,
    input  wire logic                wr_en,
    input  wire logic                wr_key_en,
    input  wire logic [IDX_BITS-1:0] wr_addr,
    input  wire logic [1:0]          wr_mark,
    input  wire logic [KEY_BITS-1:0] wr_key
);
    localparam int DEPTH = 1 << IDX_BITS;

    logic [1:0]          mark_mem [DEPTH];
    logic [KEY_BITS-1:0] key_mem  [DEPTH];

    // Write marks and keys
    always_ff @(posedge aclk) begin
        if (wr_en)
            mark_mem[wr_addr] <= wr_mark;
        if (wr_key_en)
            key_mem[wr_addr] <= wr_key;
    end

    // Registered read of mark and key
    always_ff @(posedge aclk) begin
        rd_mark <= mark_mem[rd_addr];
        rd_key  <= key_mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hash_set_linear_probe.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Ports
// s_        in         s_valid s_ready s_mode s_key s_key_hash
// m_        out        m_valid m_ready m_found m_slot m_element_count m_status
// cfg       in         cfg_we cfg_wdata (table_size)
// Steps: accept, hash modulo, a read and a check per probed slot, result.
// An ignored mode goes from accept straight to result. The probe loop is
// bound by the registered read of the slot memory. After reset, a clearing
// pass marks every slot empty; no item is taken then. A result waits in
// its output register until taken; the next item is accepted while it waits,
// and its finished result holds in the done state until the register frees.
module hash_set_linear_probe #(
    parameter int SLOTS    = 256,
    parameter int KEY_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [31:0] s_key,
    input  wire logic [31:0] s_key_hash,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [7:0]       m_slot,
    output logic [8:0]       m_element_count,
    output logic             m_status
);
    localparam int IB = $clog2(SLOTS);
    localparam int CB = IB + 1;

    hslp_pkg::state_t state_reg, state_next;

    logic [8:0]          tsize_reg;
    logic [1:0]          mode_reg, mode_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [IB-1:0]       idx_reg, idx_next;
    logic [CB-1:0]       left_reg, left_next;
    logic                tomb_v_reg, tomb_v_next;
    logic [IB-1:0]       tomb_reg, tomb_next;
    logic [CB-1:0]       count_reg, count_next;
    logic [IB-1:0]       clr_reg, clr_next;
    logic                ov_reg, ov_next;
    logic                of_reg, of_next;
    logic [IB-1:0]       os_reg, os_next;
    logic                ost_reg, ost_next;
    logic                mf_reg, mf_next;
    logic [IB-1:0]       ms_reg, ms_next;
    logic                mst_reg, mst_next;
    logic [CB-1:0]       mc_reg, mc_next;

    logic [CB-1:0]       nsize;
    logic                mod_start, mod_done;
    logic [IB-1:0]       mod_rem;
    logic [1:0]          rd_mark;
    logic [KEY_BITS-1:0] rd_key;
    logic                wr_en, wr_key_en;
    logic [IB-1:0]       wr_addr;
    logic [1:0]          wr_mark;
    logic [IB-1:0]       idx_inc;

    // Clamp table size to 1..SLOTS
    always_comb begin
        if (tsize_reg == 9'd0)
            nsize = CB'(1);
        else if (32'(tsize_reg) > SLOTS)
            nsize = CB'(SLOTS);
        else
            nsize = CB'(tsize_reg);
    end

    hslp_mod #(.HASH_BITS(32), .IDX_BITS(IB)) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (s_key_hash),
        .divisor   (nsize),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    hslp_store #(.IDX_BITS(IB), .KEY_BITS(KEY_BITS)) u_store (
        .aclk      (aclk),
        .rd_addr   (idx_reg),
        .rd_mark   (rd_mark),
        .rd_key    (rd_key),
        .wr_en     (wr_en),
        .wr_key_en (wr_key_en),
        .wr_addr   (wr_addr),
        .wr_mark   (wr_mark),
        .wr_key    (key_reg)
    );

    assign idx_inc = ({1'b0, idx_reg} + 1'b1 >= nsize) ? '0 : idx_reg + 1'b1;

    // Sequence probe: state, memory writes, result
    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        left_next   = left_reg;
        tomb_v_next = tomb_v_reg;
        tomb_next   = tomb_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        ov_next     = ov_reg;
        of_next     = of_reg;
        os_next     = os_reg;
        ost_next    = ost_reg;
        mf_next     = mf_reg;
        ms_next     = ms_reg;
        mst_next    = mst_reg;
        mc_next     = mc_reg;
        mod_start   = 1'b0;
        wr_en       = 1'b0;
        wr_key_en   = 1'b0;
        wr_addr     = idx_reg;
        wr_mark     = hslp_pkg::MARK_EMPTY;
        s_ready     = 1'b0;

        if (ov_reg && m_ready)
            ov_next = 1'b0;

        case (state_reg)
            hslp_pkg::ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IB'(SLOTS - 1))
                    state_next = hslp_pkg::ST_IDLE;
            end
            hslp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    mode_next   = s_mode;
                    key_next    = s_key[KEY_BITS-1:0];
                    tomb_v_next = 1'b0;
                    if (s_mode == hslp_pkg::MODE_IGNORED) begin
                        of_next    = 1'b0;
                        os_next    = '0;
                        ost_next   = hslp_pkg::STATUS_OK;
                        state_next = hslp_pkg::ST_DONE;
                    end else begin
                        state_next = hslp_pkg::ST_MOD;
                        mod_start  = 1'b1;
                    end
                end
            end
            hslp_pkg::ST_MOD: begin
                // skip the start cycle flag: done goes low next cycle
                if (mod_done && !mod_start && left_reg == CB'(1)) begin
                    idx_next   = mod_rem;
                    left_next  = nsize;
                    state_next = hslp_pkg::ST_READ;
                end else begin
                    left_next = CB'(1);
                end
            end
            hslp_pkg::ST_READ: begin
                state_next = hslp_pkg::ST_CHECK;
            end
            hslp_pkg::ST_CHECK: begin
                state_next = hslp_pkg::ST_DONE;
                ost_next   = hslp_pkg::STATUS_OK;
                if (rd_mark == hslp_pkg::MARK_FILLED && rd_key == key_reg) begin
                    of_next = 1'b1;
                    os_next = (mode_reg == hslp_pkg::MODE_REMOVE && count_reg == '0)
                              ? '0 : idx_reg;
                    if (mode_reg == hslp_pkg::MODE_REMOVE && count_reg != '0) begin
                        wr_en      = 1'b1;
                        wr_mark    = hslp_pkg::MARK_DELETED;
                        count_next = count_reg - 1'b1;
                    end
                end else if (rd_mark == hslp_pkg::MARK_EMPTY || left_reg == CB'(1)) begin
                    of_next = 1'b0;
                    os_next = '0;
                    if (mode_reg == hslp_pkg::MODE_ADD) begin
                        if (rd_mark == hslp_pkg::MARK_EMPTY || tomb_v_reg
                            || rd_mark == hslp_pkg::MARK_DELETED) begin
                            wr_addr = tomb_v_reg ? tomb_reg : idx_reg;
                            wr_en      = 1'b1;
                            wr_key_en  = 1'b1;
                            wr_mark    = hslp_pkg::MARK_FILLED;
                            os_next    = wr_addr;
                            count_next = count_reg + 1'b1;
                        end else begin
                            ost_next = hslp_pkg::STATUS_FULL;
                        end
                    end
                end else begin
                    if (rd_mark == hslp_pkg::MARK_DELETED && !tomb_v_reg) begin
                        tomb_v_next = 1'b1;
                        tomb_next   = idx_reg;
                    end
                    idx_next   = idx_inc;
                    left_next  = left_reg - 1'b1;
                    state_next = hslp_pkg::ST_READ;
                end
            end
            hslp_pkg::ST_DONE: begin
                // Hold the finished item until the output register is free
                if (!ov_reg || m_ready) begin
                    ov_next    = 1'b1;
                    mf_next    = of_reg;
                    ms_next    = os_reg;
                    mst_next   = ost_reg;
                    mc_next    = count_reg;
                    state_next = hslp_pkg::ST_IDLE;
                end
            end
            default: state_next = hslp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hslp_pkg::ST_CLEAR;
            tsize_reg <= 9'd256;
            count_reg <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we)
                tsize_reg <= cfg_wdata;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        left_reg   <= left_next;
        tomb_v_reg <= tomb_v_next;
        tomb_reg   <= tomb_next;
        of_reg     <= of_next;
        os_reg     <= os_next;
        ost_reg    <= ost_next;
        mf_reg     <= mf_next;
        ms_reg     <= ms_next;
        mst_reg    <= mst_next;
        mc_reg     <= mc_next;
    end

    assign m_valid         = ov_reg;
    assign m_found         = mf_reg;
    assign m_slot          = 8'(ms_reg);
    assign m_element_count = 9'(mc_reg);
    assign m_status        = mst_reg;
endmodule
`default_nettype wire
